### design/mtd_pkg.sv
// shared widths, register and format codes, and the morton interleave
// for the morton tile detile address block
// no dependencies
package mtd_pkg;

    // field widths
    localparam int COORD_W = 13;
    localparam int DIM_W   = 14;
    localparam int FMT_W   = 5;
    localparam int OFS_W   = 31;
    localparam int BYTES_W = 5;
    localparam int SHIFT_W = 3;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 14;

    // micro-tile side in blocks, a power of two
    localparam int MICRO_TILE   = 8;
    localparam int MT_LOG2      = $clog2(MICRO_TILE);
    localparam int Z_W          = 2 * MT_LOG2;
    localparam int TILE_COORD_W = COORD_W - MT_LOG2;
    localparam int TILES_W      = DIM_W - MT_LOG2 + 1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TILED  = 8'd3;

    // first and last codes of the format ranges
    localparam logic [FMT_W-1:0] FMT_LAST_1B     = 5'd2;
    localparam logic [FMT_W-1:0] FMT_LAST_2B     = 5'd8;
    localparam logic [FMT_W-1:0] FMT_LAST_4B     = 5'd13;
    localparam logic [FMT_W-1:0] FMT_FIRST_BC    = 5'd14;
    localparam logic [FMT_W-1:0] FMT_LAST_8B_BC  = 5'd15;
    localparam logic [FMT_W-1:0] FMT_LAST_BC     = 5'd18;
    localparam logic [FMT_W-1:0] FMT_LAST_8B     = 5'd21;
    localparam logic [FMT_W-1:0] FMT_16B         = 5'd22;

    // log2 of bytes per block
    localparam logic [SHIFT_W-1:0] BPB_1  = 3'd0;
    localparam logic [SHIFT_W-1:0] BPB_2  = 3'd1;
    localparam logic [SHIFT_W-1:0] BPB_4  = 3'd2;
    localparam logic [SHIFT_W-1:0] BPB_8  = 3'd3;
    localparam logic [SHIFT_W-1:0] BPB_16 = 3'd4;

    // texture geometry derived from the configuration registers
    typedef struct packed {
        logic [DIM_W-1:0]   grid_cols;
        logic [DIM_W-1:0]   grid_rows;
        logic [TILES_W-1:0] tiles_x;
        logic [SHIFT_W-1:0] bpb_log2;
        logic               tiled;
    } mtd_geom_t;

    // interleave: x in even bits, y in odd bits
    function automatic logic [Z_W-1:0] morton(input logic [MT_LOG2-1:0] x,
                                              input logic [MT_LOG2-1:0] y);
        logic [Z_W-1:0] z;
        z = '0;
        for (int i = 0; i < MT_LOG2; i++)
        begin
            z[2*i]   = x[i];
            z[2*i+1] = y[i];
        end
        return z;
    endfunction

endpackage

### design/mtd_cfg.sv
// configuration registers and derived texture geometry
// depends on mtd_pkg
module mtd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [mtd_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0]  wr_data,
    output mtd_pkg::mtd_geom_t              geom
);
    import mtd_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [FMT_W-1:0] format_reg, format_next;
    logic             tiled_reg, tiled_next;

    logic             four_by_four;
    logic [DIM_W:0]   tiles_sum;
    logic [DIM_W-1:0]   grid_cols, grid_rows;
    logic [TILES_W-1:0] tiles_x;
    logic [SHIFT_W-1:0] bpb_log2;

    // register writes, unknown indexes ignored
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        format_next = format_reg;
        tiled_next  = tiled_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_WIDTH:  width_next  = wr_data[DIM_W-1:0];
                REG_HEIGHT: height_next = wr_data[DIM_W-1:0];
                REG_FORMAT: format_next = wr_data[FMT_W-1:0];
                REG_TILED:  tiled_next  = wr_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            format_reg <= '0;
            tiled_reg  <= 1'b1;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            format_reg <= format_next;
            tiled_reg  <= tiled_next;
        end
    end

    // compressed formats cover 4x4 texels per block
    assign four_by_four = (format_reg >= FMT_FIRST_BC) && (format_reg <= FMT_LAST_BC);

    // block grid, rounded up
    always_comb
    begin
        if (four_by_four)
        begin
            grid_cols = DIM_W'(({1'b0, width_reg} + (DIM_W+1)'(3)) >> 2);
            grid_rows = DIM_W'(({1'b0, height_reg} + (DIM_W+1)'(3)) >> 2);
        end
        else
        begin
            grid_cols = width_reg;
            grid_rows = height_reg;
        end
    end

    // micro-tiles per row, rounded up
    assign tiles_sum = {1'b0, grid_cols} + (DIM_W+1)'(MICRO_TILE - 1);
    assign tiles_x   = TILES_W'(tiles_sum >> MT_LOG2);

    // bytes per block as a shift amount
    always_comb
    begin
        if (format_reg <= FMT_LAST_1B)
            bpb_log2 = BPB_1;
        else if (format_reg <= FMT_LAST_2B)
            bpb_log2 = BPB_2;
        else if (format_reg <= FMT_LAST_4B)
            bpb_log2 = BPB_4;
        else if (format_reg <= FMT_LAST_8B_BC)
            bpb_log2 = BPB_8;
        else if (format_reg <= FMT_LAST_BC)
            bpb_log2 = BPB_16;
        else if (format_reg <= FMT_LAST_8B)
            bpb_log2 = BPB_8;
        else if (format_reg == FMT_16B)
            bpb_log2 = BPB_16;
        else
            bpb_log2 = BPB_4;
    end

    // geometry bundle, fields in declaration order
    assign geom = {grid_cols, grid_rows, tiles_x, bpb_log2, tiled_reg};

endmodule

### design/morton_tile_detile_address.sv
// morton tile detile address generator, top level
// a result reaches the master side through the stage 1, 2, 3 and 4 registers
// throughput: one block coordinate per cycle while the master side accepts, set by the
// four-stage pipeline (check and interleave, multiply, add, scale); a stall holds the full stages
// reset: width 1, height 1, format 0, tiled mode on, pipeline empty
// depends on mtd_pkg and mtd_cfg
module morton_tile_detile_address (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mtd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // block coordinates
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // block_x[12:0], block_y[25:13]
    // block offsets
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [71:0]                     m_axis_tdata,  // source_offset[30:0],
                                                           // linear_offset[61:31],
                                                           // block_bytes[66:62]
    output logic                            m_axis_tuser   // outside_grid[0]
);
    import mtd_pkg::*;

    localparam int LIN_ROW_W  = COORD_W + DIM_W;
    localparam int TILE_ROW_W = TILE_COORD_W + TILES_W;
    localparam int OUT_DATA_W = 2 * OFS_W + BYTES_W;

    mtd_geom_t geom;

    logic en1, en2, en3, en4;

    logic                  s1_valid_reg;
    logic [COORD_W-1:0]    s1_bx_reg, s1_by_reg;
    logic [Z_W-1:0]        s1_z_reg;
    logic                  s1_outside_reg;

    logic                  s2_valid_reg;
    logic [LIN_ROW_W-1:0]  s2_lin_row_reg;
    logic [TILE_ROW_W-1:0] s2_tile_row_reg;
    logic [COORD_W-1:0]    s2_bx_reg;
    logic [Z_W-1:0]        s2_z_reg;
    logic                  s2_outside_reg;

    logic                  s3_valid_reg;
    logic [OFS_W-1:0]      s3_lin_idx_reg, s3_src_idx_reg;
    logic                  s3_outside_reg;

    logic                  s4_valid_reg;
    logic [OFS_W-1:0]      s4_src_reg, s4_lin_reg;
    logic [BYTES_W-1:0]    s4_bytes_reg;
    logic                  s4_outside_reg;

    logic [COORD_W-1:0]    in_bx, in_by;
    logic [Z_W-1:0]        s1_z_next;
    logic                  s1_outside_next;
    logic [OFS_W-1:0]      s3_tile_idx;
    logic [OFS_W-1:0]      s4_lin_next, s4_src_next;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    mtd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .geom     (geom)
    );

    // stage enables: a stage loads when empty or when it moves on
    assign en4 = !s4_valid_reg || m_axis_tready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign s_axis_tready = en1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= s_axis_tvalid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: grid check and in-tile interleave
    assign in_bx = s_axis_tdata[COORD_W-1:0];
    assign in_by = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign s1_z_next = morton(in_bx[MT_LOG2-1:0], in_by[MT_LOG2-1:0]);
    assign s1_outside_next = (DIM_W'(in_bx) >= geom.grid_cols) ||
                             (DIM_W'(in_by) >= geom.grid_rows);

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            s1_bx_reg      <= in_bx;
            s1_by_reg      <= in_by;
            s1_z_reg       <= s1_z_next;
            s1_outside_reg <= s1_outside_next;
        end
    end

    // stage 2: row products for the linear and tiled layouts
    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_lin_row_reg  <= LIN_ROW_W'(s1_by_reg) * LIN_ROW_W'(geom.grid_cols);
            s2_tile_row_reg <= TILE_ROW_W'(s1_by_reg[COORD_W-1:MT_LOG2]) *
                               TILE_ROW_W'(geom.tiles_x);
            s2_bx_reg       <= s1_bx_reg;
            s2_z_reg        <= s1_z_reg;
            s2_outside_reg  <= s1_outside_reg;
        end
    end

    // stage 3: block indexes in both layouts
    assign s3_tile_idx = OFS_W'(s2_tile_row_reg) + OFS_W'(s2_bx_reg[COORD_W-1:MT_LOG2]);

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_lin_idx_reg <= OFS_W'(s2_lin_row_reg) + OFS_W'(s2_bx_reg);
            s3_src_idx_reg <= (s3_tile_idx << Z_W) | OFS_W'(s2_z_reg);
            s3_outside_reg <= s2_outside_reg;
        end
    end

    // stage 4: scale by bytes per block, zero outside the grid
    always_comb
    begin
        s4_lin_next = s3_lin_idx_reg << geom.bpb_log2;
        if (geom.tiled)
            s4_src_next = s3_src_idx_reg << geom.bpb_log2;
        else
            s4_src_next = s4_lin_next;
        if (s3_outside_reg)
        begin
            s4_lin_next = '0;
            s4_src_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            s4_src_reg     <= s4_src_next;
            s4_lin_reg     <= s4_lin_next;
            s4_bytes_reg   <= BYTES_W'(1) << geom.bpb_log2;
            s4_outside_reg <= s3_outside_reg;
        end
    end

    // master side
    assign m_axis_tvalid = s4_valid_reg;
    assign m_axis_tdata  = {(72 - OUT_DATA_W)'(0), s4_bytes_reg, s4_lin_reg, s4_src_reg};
    assign m_axis_tuser  = s4_outside_reg;

endmodule

### bench/morton_tile_detile_address_tb.sv
// self-checking bench for the morton tile detile address block: block coordinates go in,
// predicted offsets, block bytes and outside flags are checked against every result transfer
// depends on mtd_pkg and morton_tile_detile_address
module morton_tile_detile_address_tb;
    import mtd_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_COORDS = 60;
    localparam int NUM_FORMATS  = 1 << FMT_W;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int DIM_MAX      = (1 << DIM_W) - 1;
    // index past the register list, writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 8'hFF;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } coord_t;

    typedef struct {
        logic [OFS_W-1:0]   source_offset;
        logic [OFS_W-1:0]   linear_offset;
        logic [BYTES_W-1:0] block_bytes;
        logic               outside_grid;
    } offsets_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [71:0]            m_axis_tdata;
    logic                   m_axis_tuser;

    // copy of the texture configuration, updated on each register transfer
    logic [DIM_W-1:0] tex_width  = DIM_W'(1);
    logic [DIM_W-1:0] tex_height = DIM_W'(1);
    logic [FMT_W-1:0] tex_format = '0;
    logic             tex_tiled  = 1'b1;

    coord_t   coords_pending[$];
    offsets_t offsets_due[$];
    int       coords_queued = 0;
    int       coords_accepted = 0;
    int       errors = 0;
    int       cycle_count = 0;
    int       gap_left = 0;
    int       valid_burst = 0;
    int       stall_left = 0;
    int       ready_burst = 0;

    morton_tile_detile_address u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // bytes per block for a format code
    function automatic int format_bytes(input logic [FMT_W-1:0] f);
        if (f <= FMT_LAST_1B)
            return 1;
        if (f <= FMT_LAST_2B)
            return 2;
        if (f <= FMT_LAST_4B)
            return 4;
        if (f <= FMT_LAST_8B_BC)
            return 8;
        if (f <= FMT_LAST_BC)
            return 16;
        if (f <= FMT_LAST_8B)
            return 8;
        if (f == FMT_16B)
            return 16;
        return 4;
    endfunction

    // blocks along one side for the current format
    function automatic int blocks_along(input logic [DIM_W-1:0] texels);
        int side;
        side = (tex_format >= FMT_FIRST_BC && tex_format <= FMT_LAST_BC) ? 4 : 1;
        return (int'(texels) + side - 1) / side;
    endfunction

    function automatic offsets_t predict_offsets(input coord_t c);
        offsets_t          r;
        longint unsigned   bpb, bxs, bys, tiles_x, tile, lin, src;
        logic [63:0]       z;
        bpb = format_bytes(tex_format);
        bxs = blocks_along(tex_width);
        bys = blocks_along(tex_height);
        r.block_bytes  = bpb[BYTES_W-1:0];
        r.outside_grid = (c.x >= bxs) || (c.y >= bys);
        lin = 0;
        src = 0;
        if (!r.outside_grid)
        begin
            lin = (c.y * bxs + c.x) * bpb;
            if (tex_tiled)
            begin
                tiles_x = (bxs + MICRO_TILE - 1) / MICRO_TILE;
                tile = (c.y / MICRO_TILE) * tiles_x + c.x / MICRO_TILE;
                // z-order inside the micro-tile: x on even bits, y on odd bits
                z = '0;
                for (int i = 0; i < $clog2(MICRO_TILE); i++)
                begin
                    z[2*i]   = c.x[i];
                    z[2*i+1] = c.y[i];
                end
                src = (tile * MICRO_TILE * MICRO_TILE + z) * bpb;
            end
            else
                src = lin;
        end
        r.source_offset = src[OFS_W-1:0];
        r.linear_offset = lin[OFS_W-1:0];
        return r;
    endfunction

    // idle length for either side: mostly short, a few long, with idle-free bursts
    function automatic int next_idle(inout int burst_left);
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 100);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // coordinate in the grid, or anywhere in the field range
    function automatic logic [COORD_W-1:0] pick_coord(input int limit, input bit inside_grid);
        if (inside_grid && limit > 0)
            return COORD_W'($urandom_range(0, (limit > COORD_MAX ? COORD_MAX : limit - 1)));
        if (limit <= COORD_MAX && $urandom_range(0, 1) != 0)
            return COORD_W'(limit);
        return COORD_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return DIM_W'(0);
        if (r == 1)
            return DIM_W'(1);
        if (r == 2)
            return DIM_W'(DIM_MAX);
        if (r == 3)
            return DIM_W'(8192);
        if (r < 10)
            return DIM_W'($urandom_range(1, 64));
        if (r < 16)
            return DIM_W'($urandom_range(65, 1024));
        return DIM_W'($urandom_range(1, DIM_MAX));
    endfunction

    task automatic queue_coord(input int x, input int y);
        coord_t c;
        c.x = COORD_W'(x);
        c.y = COORD_W'(y);
        coords_pending.insert(coords_pending.size(), c);
        coords_queued++;
    endtask

    task automatic queue_random_coords(input int count);
        int bxs, bys, r;
        coord_t c;
        bxs = blocks_along(tex_width);
        bys = blocks_along(tex_height);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 9);
            c.x = pick_coord(bxs, r != 8);
            c.y = pick_coord(bys, r != 9);
            coords_pending.insert(coords_pending.size(), c);
            coords_queued++;
        end
    endtask

    // one register write; the copy follows at the transfer edge
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_WIDTH:  tex_width  = data;
            REG_HEIGHT: tex_height = data;
            REG_FORMAT: tex_format = data[FMT_W-1:0];
            REG_TILED:  tex_tiled  = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // upper bits beyond the register width are noise the block must drop
    task automatic write_texture(input int width, input int height, input int format,
                                 input bit tiled);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_register(REG_WIDTH, CFG_DATA_W'(width));
        write_register(REG_HEIGHT, CFG_DATA_W'(height));
        write_register(REG_FORMAT, {noise[CFG_DATA_W-1:FMT_W], format[FMT_W-1:0]});
        write_register(REG_TILED, {noise[CFG_DATA_W-1:1], tiled});
    endtask

    // wait until every queued coordinate has gone through and its result is back
    task automatic drain();
        do
            @(posedge clk);
        while (coords_accepted != coords_queued || offsets_due.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // coordinate driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                offsets_due.insert(offsets_due.size(),
                                   predict_offsets('{x: s_axis_tdata[COORD_W-1:0],
                                                     y: s_axis_tdata[2*COORD_W-1:COORD_W]}));
                coords_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    gap_left--;
                end
                else if (coords_pending.size() != 0)
                begin
                    coord_t c;
                    c = coords_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(32 - 2 * COORD_W){1'b0}}, c.y, c.x};
                    gap_left = next_idle(valid_burst);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                offsets_t want, got;
                got.source_offset = m_axis_tdata[OFS_W-1:0];
                got.linear_offset = m_axis_tdata[2*OFS_W-1:OFS_W];
                got.block_bytes   = m_axis_tdata[2*OFS_W+BYTES_W-1:2*OFS_W];
                got.outside_grid  = m_axis_tuser;
                if (offsets_due.size() == 0)
                begin
                    $display("%0t: unexpected result transfer src %0d lin %0d",
                             $time, got.source_offset, got.linear_offset);
                    errors++;
                end
                else
                begin
                    want = offsets_due.pop_front();
                    if (got.source_offset !== want.source_offset)
                    begin
                        $display("%0t: source_offset expected %0d got %0d",
                                 $time, want.source_offset, got.source_offset);
                        errors++;
                    end
                    if (got.linear_offset !== want.linear_offset)
                    begin
                        $display("%0t: linear_offset expected %0d got %0d",
                                 $time, want.linear_offset, got.linear_offset);
                        errors++;
                    end
                    if (got.block_bytes !== want.block_bytes)
                    begin
                        $display("%0t: block_bytes expected %0d got %0d",
                                 $time, want.block_bytes, got.block_bytes);
                        errors++;
                    end
                    if (got.outside_grid !== want.outside_grid)
                    begin
                        $display("%0t: outside_grid expected %0b got %0b",
                                 $time, want.outside_grid, got.outside_grid);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = next_idle(ready_burst);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: a single 1-byte texel, tiled
        queue_coord(0, 0);
        queue_coord(1, 0);
        queue_coord(0, 1);
        queue_coord(COORD_MAX, COORD_MAX);
        drain();

        // 4x4 blocks of 16 bytes, 25 x 15 block grid, micro-tile corners and grid edges
        write_texture(100, 60, FMT_LAST_BC, 1'b1);
        queue_coord(0, 0);
        queue_coord(24, 14);
        queue_coord(25, 0);
        queue_coord(0, 15);
        queue_coord(7, 7);
        queue_coord(8, 8);
        queue_coord(5, 3);
        queue_coord(24, 0);
        queue_coord(COORD_MAX, 0);
        queue_coord(0, COORD_MAX);
        drain();

        // linear source, then an ignored write past the register list
        write_register(REG_TILED, CFG_DATA_W'(0));
        write_register(REG_NONE, CFG_DATA_W'($urandom));
        queue_coord(24, 14);
        queue_coord(3, 9);
        drain();

        // empty grid
        write_register(REG_WIDTH, CFG_DATA_W'(0));
        queue_coord(0, 0);
        drain();

        // largest texture and largest block bytes, alternating bit patterns
        write_texture(DIM_MAX, DIM_MAX, FMT_16B, 1'b1);
        queue_coord(COORD_MAX, COORD_MAX);
        queue_coord(13'h1555, 13'h0AAA);
        queue_coord(13'h0AAA, 13'h1555);
        queue_coord(0, 0);
        drain();

        // random phases, one per format code
        for (int f = 0; f < NUM_FORMATS; f++)
        begin
            write_texture(pick_dim(), pick_dim(), f, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                write_register(REG_NONE, CFG_DATA_W'($urandom));
            queue_random_coords(PHASE_COORDS);
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
design/mtd_pkg.sv
design/mtd_cfg.sv
design/morton_tile_detile_address.sv
bench/morton_tile_detile_address_tb.sv
